>>> src/lzf80_pkg.sv
// Package for the Format80 section decompressor.
// Holds shared widths, command codes, error codes, header codes and the APB address; no dependencies.
package lzf80_pkg;
	localparam int unsigned HISTORY_DEPTH_DEF = 65536;
	localparam int unsigned POS_W = 16;

	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_START = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SOURCE    = 3'd1;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
	localparam logic [2:0] ERR_LITERAL   = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;
	localparam logic [2:0] ERR_BUSY      = 3'd5;

	localparam logic [7:0] HDR_LONG_COPY = 8'hFF;
	localparam logic [7:0] HDR_FILL      = 8'hFE;
	localparam logic [7:0] HDR_SEL_MASK  = 8'hC0;
	localparam logic [7:0] HDR_SEL_LIT   = 8'h80;
	localparam logic [7:0] HDR_CNT6_MASK = 8'h3F;

	localparam logic [0:0] APB_ADDR_SECTION_LENGTH = 1'b0;
endpackage

>>> src/lzf80_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module lzf80_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> src/lz_format80_decompressor.sv
// Format80 (LCW) section decompressor: parses packed bytes one beat at a time,
// emits literal bytes at once and drains copy and fill runs one byte for each
// tick beat, reading the section's own output back from a history RAM. One beat
// is taken every clock cycle while in_stall is low. Every beat yields exactly one
// result beat, which passes the parse/read stage and the history RAM read and
// result stage on its way to the skid buffer and the result port. The stage-2
// register is followed by a four-entry skid buffer. Stall on the input depends
// only on registers: it rises when the results held in the buffer plus those
// still in the two stages reach four. With the receiver taking a beat every
// cycle, three results are in hand at once, so the input keeps flowing. When
// the receiver holds off, the two results still in the stages can always land
// in the buffer.
// The registered RAM read is covered by forwarding: when a copy reads the byte
// written by the beat directly before (a distance of one), the byte is taken
// from the write path rather than the RAM. The history RAM needs no clearing
// pass; the source checks never let a copy read an entry that was not written
// in the current section. section_length lies at APB byte address 0 and must
// only be written while the block is idle.
module lz_format80_decompressor
	#(
	parameter int unsigned HISTORY_DEPTH = lzf80_pkg::HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        busy_res,
	output logic        done_res,
	output logic [2:0]  error_code,
	output logic [15:0] written_count
);
	import lzf80_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);

	typedef enum logic [2:0] {
		PH_IDLE, PH_CNT_LO, PH_CNT_HI, PH_POS_LO, PH_POS_HI, PH_FILL, PH_LIT, PH_REL
	} phase_t;

	typedef enum logic [1:0] {RK_NONE, RK_COPY, RK_FILL} run_t;

	// Result of one beat, as it travels through the stage and the skid buffer.
	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
		logic        busy;
		logic        done;
		logic [2:0]  err;
		logic [15:0] count;
	} res_t;

	// Source of the output byte, resolved from the stage-1 registers in the cycle after the beat is accepted.
	typedef enum logic [1:0] {SRC_NONE, SRC_DIRECT, SRC_RAM, SRC_FWD} bsrc_t;

	// Configuration.
	logic [15:0] section_length_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_length_q <= '0;
		end else if (cfg_wr && paddr[2] == APB_ADDR_SECTION_LENGTH) begin
			section_length_q <= pwdata[15:0];
		end
	end
	assign prdata = (paddr[2] == APB_ADDR_SECTION_LENGTH) ? {16'd0, section_length_q} : '0;

	// Skid buffer: four entries behind the stage-2 register.
	res_t  skid_q [4];
	logic [2:0] skid_cnt_q;
	logic [1:0] skid_rd_q;
	logic [1:0] skid_wr_q;
	logic  s2_valid_s2;
	res_t  s2_res;
	logic  accept_in;
	logic  pop;

	// Count of results in flight; input stalls when these and the stored ones leave no room.
	logic [1:0] inflight;
	logic        s1_valid_s1;
	assign inflight = 2'(s1_valid_s1) + 2'(s2_valid_s2);
	assign in_stall = (skid_cnt_q + 3'(inflight)) >= 3'd4;
	assign accept_in = in_valid && !in_stall;

	// Architectural state.
	phase_t      phase_q;
	run_t        run_kind_q;
	logic [15:0] wpos_q;
	logic [15:0] run_rem_q;
	logic [16:0] run_src_q;
	logic [7:0]  header_q;
	logic [15:0] param_q;
	logic [7:0]  fill_q;
	logic [2:0]  err_q;
	logic        done_q;

	// Next-state logic.
	phase_t      phase_d;
	run_t        run_kind_d;
	logic [15:0] wpos_d;
	logic [15:0] run_rem_d;
	logic [16:0] run_src_d;
	logic [7:0]  header_d;
	logic [15:0] param_d;
	logic [7:0]  fill_d;
	logic [2:0]  err_d;
	logic        done_d;
	logic        emit;
	bsrc_t       bsrc;
	logic [7:0]  direct_byte;
	logic        ram_we;

	logic [16:0] rel_dist;
	logic [16:0] copy_pos;
	logic [16:0] copy_cnt;
	logic        below_zero;
	logic        chk_copy;
	logic        chk_fill;
	logic [5:0]  n6;
	logic [16:0] sl17;
	logic [16:0] wp17;
	logic        src_bad;
	logic        out_bad;
	logic        lit_out_bad;

	always_comb begin
		rel_dist = {5'd0, header_q[3:0], in_byte};
		sl17 = {1'b0, section_length_q};
		wp17 = {1'b0, wpos_q};
		n6 = in_byte[5:0];
		copy_cnt = 17'd0;
		copy_pos = 17'd0;
		below_zero = 1'b0;
		chk_copy = 1'b0;
		chk_fill = 1'b0;
		unique case (phase_q)
			PH_POS_HI: begin
				chk_copy = 1'b1;
				copy_pos = {1'b0, in_byte, param_q[7:0]};
				copy_cnt = {1'b0, run_rem_q};
			end
			PH_REL: begin
				chk_copy = 1'b1;
				copy_pos = wp17 - rel_dist;
				below_zero = rel_dist > wp17;
				copy_cnt = {1'b0, run_rem_q};
			end
			PH_FILL: begin
				chk_fill = 1'b1;
				copy_cnt = {1'b0, run_rem_q};
			end
			default: ;
		endcase
		src_bad = below_zero || copy_pos >= sl17 || (copy_pos + copy_cnt) >= sl17
			|| copy_pos >= wp17;
		out_bad = wp17 >= sl17 || (wp17 + copy_cnt) > sl17;
		lit_out_bad = wp17 >= sl17 || (wp17 + 17'(n6)) > sl17;

		phase_d = phase_q;
		run_kind_d = run_kind_q;
		wpos_d = wpos_q;
		run_rem_d = run_rem_q;
		run_src_d = run_src_q;
		header_d = header_q;
		param_d = param_q;
		fill_d = fill_q;
		err_d = err_q;
		done_d = done_q;
		emit = 1'b0;
		bsrc = SRC_NONE;
		direct_byte = 8'd0;
		ram_we = 1'b0;

		unique case (cmd_t'(command))
			CMD_START: begin
				wpos_d = '0;
				run_rem_d = '0;
				run_src_d = '0;
				run_kind_d = RK_NONE;
				phase_d = PH_IDLE;
				header_d = '0;
				param_d = '0;
				fill_d = '0;
				err_d = ERR_NONE;
				done_d = 1'b0;
			end
			CMD_TICK: begin
				if (err_q == ERR_NONE && run_kind_q != RK_NONE) begin
					emit = 1'b1;
					ram_we = 1'b1;
					if (run_kind_q == RK_FILL) begin
						bsrc = SRC_DIRECT;
						direct_byte = fill_q;
					end else begin
						bsrc = SRC_RAM;
					end
					wpos_d = wpos_q + 16'd1;
					run_src_d = run_src_q + 17'd1;
					run_rem_d = run_rem_q - 16'd1;
					if (run_rem_q == 16'd1) begin
						run_kind_d = RK_NONE;
					end
				end
			end
			CMD_DATA: begin
				if (err_q == ERR_NONE && !done_q) begin
					if (run_kind_q != RK_NONE) begin
						err_d = ERR_BUSY;
						run_kind_d = RK_NONE;
						run_rem_d = '0;
					end else begin
						unique case (phase_q)
							PH_IDLE: begin
								header_d = in_byte;
								if (in_byte == HDR_LONG_COPY || in_byte == HDR_FILL) begin
									phase_d = PH_CNT_LO;
								end else if ((in_byte & HDR_SEL_MASK) == HDR_SEL_MASK) begin
									run_rem_d = 16'(in_byte & HDR_CNT6_MASK) + 16'd3;
									param_d = '0;
									phase_d = PH_POS_LO;
								end else if ((in_byte & HDR_SEL_MASK) == HDR_SEL_LIT) begin
									if (n6 == 6'd0) begin
										done_d = 1'b1;
									end else if (in_last) begin
										err_d = ERR_LITERAL;
									end else if (lit_out_bad) begin
										err_d = ERR_OVERFLOW;
									end else begin
										param_d = 16'(n6);
										phase_d = PH_LIT;
									end
								end else begin
									run_rem_d = 16'(in_byte[6:4]) + 16'd3;
									phase_d = PH_REL;
								end
							end
							PH_CNT_LO: begin
								run_rem_d = {8'd0, in_byte};
								phase_d = PH_CNT_HI;
							end
							PH_CNT_HI: begin
								run_rem_d = {in_byte, run_rem_q[7:0]};
								phase_d = (header_q == HDR_LONG_COPY) ? PH_POS_LO : PH_FILL;
							end
							PH_POS_LO: begin
								param_d = {8'd0, in_byte};
								phase_d = PH_POS_HI;
							end
							PH_POS_HI, PH_REL, PH_FILL: begin
								phase_d = PH_IDLE;
								if (phase_q == PH_POS_HI) begin
									param_d = {in_byte, param_q[7:0]};
								end
								if (phase_q == PH_FILL) begin
									fill_d = in_byte;
								end
								if (chk_copy && src_bad) begin
									err_d = ERR_SOURCE;
									run_kind_d = RK_NONE;
									run_rem_d = '0;
								end else if (out_bad) begin
									err_d = ERR_OVERFLOW;
									run_kind_d = RK_NONE;
									run_rem_d = '0;
								end else if (run_rem_q != 16'd0) begin
									run_kind_d = chk_fill ? RK_FILL : RK_COPY;
									if (chk_copy) begin
										run_src_d = copy_pos;
									end
								end
							end
							PH_LIT: begin
								if (in_last && param_q > 16'd1) begin
									err_d = ERR_LITERAL;
								end else begin
									emit = 1'b1;
									ram_we = 1'b1;
									bsrc = SRC_DIRECT;
									direct_byte = in_byte;
									wpos_d = wpos_q + 16'd1;
									param_d = param_q - 16'd1;
									if (param_q == 16'd1) begin
										phase_d = PH_IDLE;
									end
								end
							end
							default: ;
						endcase
						// End of input: done when the command is complete, else truncated.
						if (err_d == ERR_NONE && in_last) begin
							if (phase_d != PH_IDLE) begin
								err_d = ERR_TRUNCATED;
								run_kind_d = RK_NONE;
								run_rem_d = '0;
							end else begin
								done_d = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Stage 1 carries the result, byte source and RAM write.
	res_t        res_s1;
	bsrc_t       bsrc_s1;
	logic [7:0]  direct_s1;
	logic [AW-1:0] waddr_s1;
	logic        we_s1;
	logic [AW-1:0] raddr;
	logic        fwd_hit;

	assign raddr = run_src_q[AW-1:0];
	// The byte at the source was written by the beat now in stage 1.
	assign fwd_hit = we_s1 && s1_valid_s1 && waddr_s1 == raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			run_kind_q <= RK_NONE;
			wpos_q <= '0;
			run_rem_q <= '0;
			run_src_q <= '0;
			header_q <= '0;
			param_q <= '0;
			fill_q <= '0;
			err_q <= ERR_NONE;
			done_q <= 1'b0;
			s1_valid_s1 <= 1'b0;
			we_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= accept_in;
			we_s1 <= accept_in && ram_we;
			if (accept_in) begin
				phase_q <= phase_d;
				run_kind_q <= run_kind_d;
				wpos_q <= wpos_d;
				run_rem_q <= run_rem_d;
				run_src_q <= run_src_d;
				header_q <= header_d;
				param_q <= param_d;
				fill_q <= fill_d;
				err_q <= err_d;
				done_q <= done_d;
			end
		end
	end

	logic [7:0] byte_s1;
	logic [7:0] ram_rdata;

	always_ff @(posedge clk) begin
		if (accept_in) begin
			res_s1 <= '{valid: emit, data: 8'd0, busy: run_kind_d != RK_NONE,
				done: done_d, err: err_d, count: wpos_d};
			bsrc_s1 <= (bsrc == SRC_RAM && fwd_hit) ? SRC_FWD : bsrc;
			direct_s1 <= direct_byte;
			waddr_s1 <= wpos_q[AW-1:0];
		end
	end

	// The byte written in stage 1; a copy beat resolves it from RAM or forward path.
	logic [7:0] fwd_byte_q;
	always_comb begin
		unique case (bsrc_s1)
			SRC_DIRECT: byte_s1 = direct_s1;
			SRC_RAM:    byte_s1 = ram_rdata;
			SRC_FWD:    byte_s1 = fwd_byte_q;
			default:    byte_s1 = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			fwd_byte_q <= byte_s1;
		end
	end

	lzf80_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_history (
		.clk  (clk),
		.we   (we_s1 && s1_valid_s1),
		.waddr(waddr_s1),
		.wdata(byte_s1),
		.re   (accept_in),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Stage 2 register.
	res_t res_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else begin
			s2_valid_s2 <= s1_valid_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			res_s2 <= '{valid: res_s1.valid, data: res_s1.valid ? byte_s1 : 8'd0,
				busy: res_s1.busy, done: res_s1.done, err: res_s1.err,
				count: res_s1.count};
		end
	end
	assign s2_res = res_s2;

	// Skid FIFO: the entry at the read pointer is the head shown on the ports.
	logic push;
	assign push = s2_valid_s2;
	assign pop = res_valid && !res_stall;
	assign res_valid = skid_cnt_q != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_cnt_q <= '0;
			skid_rd_q <= '0;
			skid_wr_q <= '0;
		end else begin
			skid_cnt_q <= skid_cnt_q + 3'(push) - 3'(pop);
			skid_rd_q <= skid_rd_q + 2'(pop);
			skid_wr_q <= skid_wr_q + 2'(push);
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			skid_q[skid_wr_q] <= s2_res;
		end
	end

	assign out_valid = skid_q[skid_rd_q].valid;
	assign out_byte = skid_q[skid_rd_q].data;
	assign busy_res = skid_q[skid_rd_q].busy;
	assign done_res = skid_q[skid_rd_q].done;
	assign error_code = skid_q[skid_rd_q].err;
	assign written_count = skid_q[skid_rd_q].count;
endmodule

>>> src/lzf80_checker.sv
// Port-level checker for the Format80 decompressor, bound to the top level.
// Depends on lzf80_pkg for the error codes.
module lzf80_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic        out_valid,
	input logic [7:0]  out_byte,
	input logic [2:0]  error_code
);
	import lzf80_pkg::*;

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte))
		else $error("result changed while stalled");

	// An empty byte slot reads as zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0)
		else $error("out_byte nonzero without a byte");

	// No byte comes with an error.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && error_code != ERR_NONE |-> !out_valid)
		else $error("byte emitted with error");

	// Error codes stay in their range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> error_code <= ERR_BUSY)
		else $error("error code out of range");

	// With the output drained the input is never stalled.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !in_stall)
		else $error("input stalled with empty output");
endmodule

bind lz_format80_decompressor lzf80_sva u_lzf80_sva (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.res_valid(res_valid), .res_stall(res_stall),
	.out_valid(out_valid), .out_byte(out_byte), .error_code(error_code)
);

>>> verif/lzf80_checker.sv
// Checker for the Format80 section decompressor: follows the APB port and both beat
// channels, predicts every result beat and compares it field by field.
// Depends on lzf80_pkg for command and error codes.
module lzf80_checker
	import lzf80_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic        out_valid,
	input  logic [7:0]  out_byte,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [2:0]  error_code,
	input  logic [15:0] written_count,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		PH_IDLE, PH_CNT_LO, PH_CNT_HI, PH_POS_LO, PH_POS_HI, PH_FILL, PH_LIT, PH_REL
	} phase_t;
	typedef enum logic [1:0] {RUN_NONE, RUN_COPY, RUN_FILL} run_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
		logic        busy;
		logic        done;
		logic [2:0]  err;
		logic [15:0] count;
	} beat_result_t;

	logic [7:0]   history [HISTORY_DEPTH_DEF];
	logic [15:0]  sec_len, wpos, remain, acc;
	logic [16:0]  src;
	logic [7:0]   hdr, fill_byte;
	logic [2:0]   err;
	logic         done;
	run_t         kind;
	phase_t       phase;
	beat_result_t expected_q[$];

	assign pending = expected_q.size();

	task automatic raise_error(input logic [2:0] code);
		if (err == ERR_NONE)
			err = code;
		kind = RUN_NONE;
		remain = '0;
	endtask

	task automatic write_history(input logic [7:0] b);
		history[wpos] = b;
		wpos = wpos + 16'd1;
	endtask

	task automatic open_copy(input int pos, input int cnt, input bit below_zero);
		if (below_zero || pos >= sec_len || pos + cnt >= sec_len || pos >= wpos)
			raise_error(ERR_SOURCE);
		else if (wpos >= sec_len || int'(wpos) + cnt > sec_len)
			raise_error(ERR_OVERFLOW);
		else if (cnt != 0) begin
			kind = RUN_COPY;
			remain = cnt[15:0];
			src = pos[16:0];
		end
	endtask

	task automatic open_fill(input int cnt);
		if (wpos >= sec_len || int'(wpos) + cnt > sec_len)
			raise_error(ERR_OVERFLOW);
		else if (cnt != 0) begin
			kind = RUN_FILL;
			remain = cnt[15:0];
		end
	endtask

	// Parser for one packed byte; returns whether a literal byte went out.
	task automatic parse_packed(input logic [7:0] b, input bit last, output bit emitted,
			output logic [7:0] ob);
		int rel_dist;
		int n;
		bit tail;
		emitted = 0;
		ob = '0;
		tail = 1;
		case (phase)
			PH_IDLE: begin
				hdr = b;
				if (b == HDR_LONG_COPY || b == HDR_FILL)
					phase = PH_CNT_LO;
				else if ((b & HDR_SEL_MASK) == HDR_SEL_MASK) begin
					remain = 16'(b & HDR_CNT6_MASK) + 16'd3;
					acc = '0;
					phase = PH_POS_LO;
				end else if ((b & HDR_SEL_MASK) == HDR_SEL_LIT) begin
					n = b & HDR_CNT6_MASK;
					tail = 0;
					if (n == 0)
						done = 1;
					else if (last)
						raise_error(ERR_LITERAL);
					else if (wpos >= sec_len || int'(wpos) + n > sec_len)
						raise_error(ERR_OVERFLOW);
					else begin
						acc = n[15:0];
						phase = PH_LIT;
						tail = 1;
					end
				end else begin
					remain = 16'(b[6:4]) + 16'd3;
					phase = PH_REL;
				end
			end
			PH_CNT_LO: begin
				remain = {8'd0, b};
				phase = PH_CNT_HI;
			end
			PH_CNT_HI: begin
				remain[15:8] = b;
				phase = (hdr == HDR_LONG_COPY) ? PH_POS_LO : PH_FILL;
			end
			PH_POS_LO: begin
				acc = {8'd0, b};
				phase = PH_POS_HI;
			end
			PH_POS_HI: begin
				acc[15:8] = b;
				phase = PH_IDLE;
				open_copy(acc, remain, 0);
			end
			PH_FILL: begin
				fill_byte = b;
				phase = PH_IDLE;
				open_fill(remain);
			end
			PH_REL: begin
				rel_dist = {hdr[3:0], b};
				phase = PH_IDLE;
				open_copy((int'(wpos) - rel_dist) & 32'h1FFFF, remain, rel_dist > wpos);
			end
			default: begin
				if (last && acc > 1) begin
					raise_error(ERR_LITERAL);
					tail = 0;
				end else begin
					write_history(b);
					ob = b;
					emitted = 1;
					acc = acc - 16'd1;
					if (acc == 0)
						phase = PH_IDLE;
				end
			end
		endcase
		if (tail && err == ERR_NONE && last) begin
			if (phase != PH_IDLE)
				raise_error(ERR_TRUNCATED);
			else
				done = 1;
		end
	endtask

	task automatic predict_beat(input cmd_t cmd, input logic [7:0] b, input bit last);
		beat_result_t r;
		bit errored;
		bit em;
		logic [7:0] ob;
		errored = (err != ERR_NONE);
		em = 0;
		ob = '0;
		case (cmd)
			CMD_START: begin
				wpos = '0; remain = '0; src = '0; kind = RUN_NONE; phase = PH_IDLE;
				hdr = '0; acc = '0; fill_byte = '0; err = ERR_NONE; done = 0;
			end
			CMD_TICK: begin
				if (!errored && kind != RUN_NONE) begin
					ob = (kind == RUN_FILL) ? fill_byte : history[src[15:0]];
					write_history(ob);
					em = 1;
					src = src + 17'd1;
					remain = remain - 16'd1;
					if (remain == 0)
						kind = RUN_NONE;
				end
			end
			CMD_DATA: begin
				if (!errored && !done) begin
					if (kind != RUN_NONE)
						raise_error(ERR_BUSY);
					else
						parse_packed(b, last, em, ob);
				end
			end
			default: ;
		endcase
		r.valid = em;
		r.data = em ? ob : 8'd0;
		r.busy = (kind != RUN_NONE);
		r.done = done;
		r.err = err;
		r.count = wpos;
		expected_q.insert(expected_q.size(), r);
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		$display("[%0t] result %0d: %s expected %0d, got %0d", $time, results_seen, field,
			want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_result_t e;
		if (!arst_n) begin
			sec_len = '0; wpos = '0; remain = '0; src = '0; kind = RUN_NONE;
			phase = PH_IDLE; hdr = '0; acc = '0; fill_byte = '0; err = ERR_NONE; done = 0;
			expected_q.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == APB_ADDR_SECTION_LENGTH)
				sec_len = pwdata[15:0];
			if (in_valid && !in_stall)
				predict_beat(cmd_t'(command), in_byte, in_last);
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result beat count", 0, 1);
				end else begin
					e = expected_q.pop_front();
					if (out_valid !== e.valid) report_mismatch("out_valid", e.valid, out_valid);
					if (out_byte !== e.data) report_mismatch("out_byte", e.data, out_byte);
					if (busy_res !== e.busy) report_mismatch("busy_res", e.busy, busy_res);
					if (done_res !== e.done) report_mismatch("done_res", e.done, done_res);
					if (error_code !== e.err) report_mismatch("error_code", e.err, error_code);
					if (written_count !== e.count)
						report_mismatch("written_count", e.count, written_count);
				end
				results_seen++;
			end
		end
	end
endmodule

>>> verif/tb.sv
// Top of the Format80 decompressor testbench: clock, reset, APB writes and beat stimulus.
// Depends on lzf80_pkg, lz_format80_decompressor and lzf80_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lzf80_pkg::*;

	localparam int TARGET_BEATS = 1750;
	localparam int STALL_LIMIT = 3000;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:2]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_stall, in_last;
	cmd_t        command;
	logic [7:0]  in_byte;
	logic        res_valid, res_stall;
	logic        out_valid, busy_res, done_res;
	logic [7:0]  out_byte;
	logic [2:0]  error_code;
	logic [15:0] written_count;
	int          fail_count, pending, results_seen;
	int          beats_sent, sections, idle_cycles;
	int          len_now, pos_gen;
	bit          burst_mode;

	lz_format80_decompressor u_top (.*);
	lzf80_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Nothing accepted on either side for too long means the block has hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver may stall before each result beat, with stretches of no stalling at all.
	// Once, after 600 results, it holds off for a long stretch so that the skid buffer fills
	// and the block has to stall its input.
	initial begin
		int wait_n;
		bit held;
		held = 0;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= 600) begin
				held = 1;
				wait_n = 400;
			end else
				wait_n = (results_seen / 150) % 3 == 1 ? 0 : $urandom_range(0, 13);
			if (wait_n > 0) begin
				res_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	// One input beat; the sender may first idle unless in a burst.
	task automatic send_beat(input cmd_t cmd, input logic [7:0] b, input bit last);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		in_byte <= b;
		in_last <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		if (beats_sent % 120 == 0)
			burst_mode = !burst_mode;
	endtask

	task automatic data_beat(input logic [7:0] b, input bit last = 1'b0);
		send_beat(CMD_DATA, b, last);
	endtask

	// Drains a run; now and then adds a tick with no run or a data byte while busy.
	task automatic drain_run(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 40) == 0)
				data_beat(8'($urandom_range(0, 255)));
			send_beat(CMD_TICK, 8'($urandom()), 1'b0);
		end
		if ($urandom_range(0, 5) == 0)
			send_beat(CMD_TICK, 8'($urandom()), 1'($urandom_range(0, 1)));
		pos_gen += n;
	endtask

	task automatic reg_write(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_SECTION_LENGTH;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits for every expected result, then lets the pipeline and skid buffer settle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_length(input int value);
		settle();
		reg_write(value);
		len_now = value;
	endtask

	// Writes a literal run of n bytes with random content.
	task automatic literal_run(input int n);
		data_beat(HDR_SEL_LIT | 8'(n));
		for (int i = 0; i < n; i++)
			data_beat(8'($urandom_range(0, 255)));
		pos_gen += n;
	endtask

	// One well-formed command with random content, mostly kept inside the section.
	task automatic random_command();
		int room, cnt, pos, rel_dist;
		room = len_now - pos_gen;
		if (room < 1) room = 1;
		case (pos_gen == 0 ? 0 : $urandom_range(0, 4))
			0: literal_run($urandom_range(1, room < 63 ? room : 63));
			1: begin
				cnt = $urandom_range(0, room < 20 ? room : 20);
				data_beat(HDR_FILL);
				data_beat(cnt[7:0]);
				data_beat(cnt[15:8]);
				data_beat(8'($urandom_range(0, 255)));
				drain_run(cnt);
			end
			2: begin
				pos = $urandom_range(0, pos_gen - 1);
				cnt = $urandom_range(0, room < 20 ? room : 20);
				if ($urandom_range(0, 9) == 0)
					pos = $urandom_range(0, 65535);
				data_beat(HDR_LONG_COPY);
				data_beat(cnt[7:0]);
				data_beat(cnt[15:8]);
				data_beat(pos[7:0]);
				data_beat(pos[15:8]);
				drain_run(pos + cnt < len_now && pos < pos_gen ? cnt : 0);
			end
			3: begin
				pos = $urandom_range(0, pos_gen - 1);
				cnt = $urandom_range(0, 9);
				data_beat(HDR_SEL_MASK | 8'(cnt));
				data_beat(pos[7:0]);
				data_beat(pos[15:8]);
				drain_run(pos + cnt + 3 < len_now && cnt + 3 <= room ? cnt + 3 : 0);
			end
			default: begin
				rel_dist = $urandom_range(1, pos_gen < 4095 ? pos_gen : 4095);
				if ($urandom_range(0, 12) == 0)
					rel_dist = $urandom_range(0, 4095);
				cnt = $urandom_range(0, 7);
				data_beat({1'b0, cnt[2:0], rel_dist[11:8]});
				data_beat(rel_dist[7:0]);
				drain_run(cnt + 3 <= room && rel_dist <= pos_gen && rel_dist > 0 ? cnt + 3 : 0);
			end
		endcase
	endtask

	// A section: mostly well-formed commands closed by one of several endings, sometimes
	// broken or plain noise.
	task automatic random_section();
		sections++;
		pos_gen = 0;
		send_beat(CMD_START, 8'($urandom()), 1'b0);
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(5, 30))
				send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom()),
					$urandom_range(0, 15) == 0);
			return;
		end
		repeat ($urandom_range(1, 10))
			random_command();
		case ($urandom_range(0, 5))
			0, 1: data_beat(HDR_SEL_LIT, 1'($urandom_range(0, 1)));
			2: begin
				data_beat(HDR_SEL_LIT | 8'd1);
				data_beat(8'($urandom_range(0, 255)), 1'b1);
			end
			3: begin
				// Last byte on a complete fill: done at once, the run still drains.
				data_beat(HDR_FILL);
				data_beat(8'd3);
				data_beat(8'd0);
				data_beat(8'($urandom_range(0, 255)), 1'b1);
				drain_run(3);
			end
			4: begin
				data_beat(HDR_LONG_COPY);
				data_beat(8'($urandom_range(0, 255)), 1'b1);
			end
			default: data_beat(HDR_SEL_LIT | 8'($urandom_range(1, 63)), 1'b1);
		endcase
		if ($urandom_range(0, 3) == 0)
			data_beat(8'($urandom_range(0, 255)));
	endtask

	initial begin
		int lengths[6];
		lengths = '{65535, 0, 1, 300, 0, 2000};
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; command = CMD_DATA; in_byte = '0; in_last = 1'b0;
		beats_sent = 0; sections = 0; idle_cycles = 0; burst_mode = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed section: literal, fill, relative and long copies, an overlapping copy and the odd cases.
		set_length(64);
		burst_mode = 1;
		pos_gen = 0;
		send_beat(CMD_START, 8'h00, 1'b0);
		send_beat(CMD_TICK, 8'h00, 1'b0);        // tick with no run
		send_beat(CMD_NOP, 8'hFF, 1'b1);         // selector three is ignored
		data_beat(HDR_SEL_LIT | 8'd2);
		data_beat(8'hFF);
		data_beat(8'h00);
		data_beat(HDR_FILL); data_beat(8'd2); data_beat(8'd0); data_beat(8'hA5);
		data_beat(8'h11);                        // data while a run is busy
		send_beat(CMD_START, 8'h00, 1'b0);
		literal_run(1);
		data_beat(8'h00); data_beat(8'h01);      // distance one, count three, overlapping
		drain_run(3);
		data_beat(HDR_LONG_COPY); data_beat(8'd2); data_beat(8'd0);
		data_beat(8'd0); data_beat(8'd0);
		drain_run(2);
		data_beat(HDR_SEL_LIT);                  // terminator
		data_beat(8'h5A);                        // data after done
		burst_mode = 0;

		for (int p = 0; p < 6; p++) begin
			set_length(p == 5 ? $urandom_range(2, 65534) : lengths[p]);
			while (beats_sent < TARGET_BEATS * (p + 1) / 6)
				random_section();
		end
		set_length(65535);
		settle();
		$display("%0d input beats in %0d sections, %0d result beats checked",
			beats_sent, sections, results_seen);
		$display("section lengths went from 0 to 65535, with one long receiver hold-off");
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
